[sv/assert_macros.svh]
// assertion macros shared by the checker files
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every rising edge outside reset
`define AM_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// antecedent in this cycle, consequent in the next
`define AM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/mgvu_pkg.sv]
// types, codes and saturation helper of the momentum gradient update block
// no dependencies
package mgvu_pkg;

	localparam int DATA_W  = 32;
	localparam int INDEX_W = 4;
	localparam int OP_W    = 2;
	localparam int COUNT_W = 8;
	localparam int SUM_W   = 58;   // widest intermediate sum before saturation
	localparam int MUL_W   = 33;   // shared multiplier operand width
	localparam int PROD_W  = 2 * MUL_W;

	localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
	localparam logic [OP_W-1:0] OP_ACCUM  = 2'd1;
	localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

	localparam logic [1:0] REG_MOMENTUM  = 2'd0;
	localparam logic [1:0] REG_STEP_SIZE = 2'd1;
	localparam logic [1:0] REG_NEIGHBOUR = 2'd2;

	localparam logic signed [DATA_W-1:0] MOMENTUM_RST  = 32'sd58982;
	localparam logic signed [DATA_W-1:0] STEP_SIZE_RST = 32'sd655;
	localparam logic [COUNT_W-1:0]       NEIGHBOUR_RST = 8'd0;

	localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [OP_W-1:0]           operation;
		logic [INDEX_W-1:0]        element_index;
		logic                      clear_first;
		logic signed [DATA_W-1:0]  error_value;
		logic signed [DATA_W-1:0]  factor_value;
		logic signed [DATA_W-1:0]  prior_sum;
		logic signed [DATA_W-1:0]  coef_value;
		logic signed [DATA_W-1:0]  load_value;
	} in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  latent_value;
		logic signed [DATA_W-1:0]  gradient_value;
		logic signed [DATA_W-1:0]  velocity_value;
	} out_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  momentum;
		logic signed [DATA_W-1:0]  step_size;
		logic [COUNT_W-1:0]        neighbour_count;
	} cfg_t;

	// clamp a wide signed sum to the q16.16 range
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
		logic [SUM_W-DATA_W:0] top;
		logic signed [DATA_W-1:0] r;
		top = x[SUM_W-1:DATA_W-1];
		if (top == '0 || top == '1) begin
			r = x[DATA_W-1:0];
		end else if (x[SUM_W-1]) begin
			r = SAT_MIN;
		end else begin
			r = SAT_MAX;
		end
		return r;
	endfunction

endpackage

[sv/mgvu_mul.sv]
// shared signed multiplier with a registered product
// uses mgvu_pkg for widths
module mgvu_mul (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic signed [mgvu_pkg::MUL_W-1:0]      a,
	input  logic signed [mgvu_pkg::MUL_W-1:0]      b,
	output logic signed [mgvu_pkg::PROD_W-1:0]     prod
);

	logic signed [mgvu_pkg::PROD_W-1:0] prod_q;

	// product holds while disabled so write-back can wait on the output
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

	assign prod = prod_q;

endmodule

[sv/mgvu_core.sv]
// sequencer, element stores and output register of the momentum update block
// uses mgvu_pkg and mgvu_mul
module mgvu_core #(
	parameter int VECTOR_LENGTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mgvu_pkg::cfg_t  cfg,
	input  logic            item_valid,
	output logic            item_stall,
	input  mgvu_pkg::in_t   item,
	output logic            result_valid,
	input  logic            result_stall,
	output mgvu_pkg::out_t  result
);

	localparam int IW        = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
	localparam int IDX_W     = mgvu_pkg::INDEX_W;
	localparam int IDX_CODES = 2 ** IDX_W;
	localparam int DW        = mgvu_pkg::DATA_W;
	localparam int SW        = mgvu_pkg::SUM_W;
	localparam int MW        = mgvu_pkg::MUL_W;
	localparam int PW        = mgvu_pkg::PROD_W;
	localparam int QW        = PW - 2 - 16;   // width of a floor-shifted product

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_MUL2 = 3'd2;
	localparam logic [2:0] ST_MUL3 = 3'd3;
	localparam logic [2:0] ST_MUL4 = 3'd4;
	localparam logic [2:0] ST_MUL5 = 3'd5;
	localparam logic [2:0] ST_MUL6 = 3'd6;
	localparam logic [2:0] ST_WB   = 3'd7;

	logic [2:0]              state_q, state_d;
	mgvu_pkg::in_t           item_q;
	logic [IW-1:0]           idx_q, idx_sel;
	logic signed [DW-1:0]    lat_q, grad_q, vel_q;
	logic signed [DW-1:0]    latent_mem   [VECTOR_LENGTH];
	logic signed [DW-1:0]    gradient_mem [VECTOR_LENGTH];
	logic signed [DW-1:0]    velocity_mem [VECTOR_LENGTH];
	logic [15:0]             nl_q;
	logic signed [SW-1:0]    acc_q;
	logic signed [QW-1:0]    a_q;
	logic                    result_valid_q;
	mgvu_pkg::out_t          result_q, res;

	logic                    mul_en;
	logic signed [MW-1:0]    mul_a, mul_b;
	logic signed [PW-1:0]    prod;
	logic signed [QW-1:0]    prod_fl;
	logic signed [DW-1:0]    v_new, lat_new, acc_new;
	logic                    accept, wb_go;

	mgvu_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign prod_fl    = prod[PW-3:16];
	assign accept     = item_valid && (state_q == ST_IDLE);
	assign item_stall = (state_q != ST_IDLE);
	assign wb_go      = (state_q == ST_WB) && (!result_valid_q || !result_stall);

	// element index folded onto the vector length
	always_comb begin
		idx_sel = '0;
		for (int k = 0; k < IDX_CODES; k++) begin
			if (item.element_index == IDX_W'(k)) begin
				idx_sel = IW'(k % VECTOR_LENGTH);
			end
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			ST_MUL1: begin
				if (item_q.operation == mgvu_pkg::OP_ACCUM) begin
					mul_a = MW'(item_q.error_value);
					mul_b = MW'(item_q.factor_value);
				end else begin
					mul_a = MW'(item_q.coef_value);
					mul_b = MW'(item_q.prior_sum);
				end
			end
			ST_MUL2: begin
				mul_a = MW'(item_q.coef_value);
				mul_b = MW'(lat_q);
			end
			ST_MUL3: begin
				// upper part of floor(coef*latent) times the count
				mul_a = MW'(signed'(prod[PW-3:32]));
				mul_b = signed'(MW'(cfg.neighbour_count));
			end
			ST_MUL4: begin
				mul_a = signed'(MW'(nl_q));
				mul_b = signed'(MW'(cfg.neighbour_count));
			end
			ST_MUL5: begin
				mul_a = MW'(cfg.momentum);
				mul_b = MW'(vel_q);
			end
			ST_MUL6: begin
				mul_a = MW'(cfg.step_size);
				mul_b = MW'(grad_q);
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// write-back values
	always_comb begin
		v_new   = mgvu_pkg::sat32(SW'(a_q) + SW'(prod_fl));
		lat_new = mgvu_pkg::sat32(SW'(lat_q) - SW'(v_new));
		if (item_q.clear_first) begin
			acc_new = mgvu_pkg::sat32(SW'(prod_fl));
		end else begin
			acc_new = mgvu_pkg::sat32(SW'(grad_q) + SW'(prod_fl));
		end
		unique case (item_q.operation)
			mgvu_pkg::OP_LOAD: begin
				res.latent_value   = item_q.load_value;
				res.gradient_value = grad_q;
				res.velocity_value = '0;
			end
			mgvu_pkg::OP_ACCUM: begin
				res.latent_value   = lat_q;
				res.gradient_value = acc_new;
				res.velocity_value = vel_q;
			end
			mgvu_pkg::OP_UPDATE: begin
				res.latent_value   = lat_new;
				res.gradient_value = grad_q;
				res.velocity_value = v_new;
			end
			default: begin
				res.latent_value   = lat_q;
				res.gradient_value = grad_q;
				res.velocity_value = vel_q;
			end
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_IDLE: begin
				if (!accept) begin
					state_d = ST_IDLE;
				end else if (item.operation == mgvu_pkg::OP_LOAD ||
						item.operation == mgvu_pkg::OP_NONE) begin
					state_d = ST_WB;
				end else begin
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: state_d = (item_q.operation == mgvu_pkg::OP_ACCUM) ? ST_WB : ST_MUL2;
			ST_MUL2: state_d = ST_MUL3;
			ST_MUL3: state_d = ST_MUL4;
			ST_MUL4: state_d = ST_MUL5;
			ST_MUL5: state_d = ST_MUL6;
			ST_MUL6: state_d = ST_WB;
			default: state_d = wb_go ? ST_IDLE : ST_WB;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wb_go) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					item_q <= item;
					idx_q  <= idx_sel;
					lat_q  <= latent_mem[idx_sel];
					grad_q <= gradient_mem[idx_sel];
					vel_q  <= velocity_mem[idx_sel];
				end
			end
			ST_MUL2: grad_q <= mgvu_pkg::sat32(SW'(grad_q) - SW'(prod_fl));
			ST_MUL3: nl_q   <= prod[31:16];
			ST_MUL4: acc_q  <= {prod[SW-17:0], 16'h0000};
			ST_MUL5: grad_q <= mgvu_pkg::sat32(SW'(grad_q) + acc_q + signed'(prod[SW-1:0]));
			ST_MUL6: a_q    <= prod_fl;
			ST_WB: begin
				if (wb_go) begin
					latent_mem[idx_q]   <= res.latent_value;
					gradient_mem[idx_q] <= res.gradient_value;
					velocity_mem[idx_q] <= res.velocity_value;
					result_q            <= res;
				end
			end
			default: ;
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[sv/momentum_gradient_vector_update.sv]
// top level of the momentum gradient update block: register port and core
// uses mgvu_pkg and mgvu_core
// usage
//  - item channel: item_valid / item_stall / item carry one transaction per
//    element operation (load, accumulate, update); a transaction is taken on
//    a rising edge with item_valid high and item_stall low
//  - result channel: result_valid / result_stall / result return one
//    transaction per item with the element's latent, gradient and velocity
//  - a load or an unused operation goes straight to write-back, an accumulate
//    uses one product and an update six; no new item is taken until write-back
//  - the products come from the single shared 33x33 multiplier: an update
//    runs its six products through it one per cycle, then writes back
//  - a finished result sits in an output register; the core takes the next
//    item while it waits, and only stalls write-back if a second result is
//    ready before the first has been taken
//  - result_stall holds result_valid and result unchanged
//  - reset clears the sequencer and the output valid and loads the register
//    defaults; element stores are not cleared and must be loaded before use
//  - registers (momentum, step_size, neighbour_count) at byte 0, 4, 8 of the
//    apb port; the user writes them only while the block is idle (not enforced)
module momentum_gradient_vector_update #(
	parameter int VECTOR_LENGTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// item channel
	input  logic                  item_valid,
	output logic                  item_stall,
	input  mgvu_pkg::in_t         item,
	// result channel
	output logic                  result_valid,
	input  logic                  result_stall,
	output mgvu_pkg::out_t        result,
	// register port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	mgvu_pkg::cfg_t cfg_q;
	logic           reg_wr;
	logic [1:0]     reg_sel;

	// register index is the word address; low byte bits ignored
	assign reg_sel = paddr[3:2];
	assign reg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.momentum        <= mgvu_pkg::MOMENTUM_RST;
			cfg_q.step_size       <= mgvu_pkg::STEP_SIZE_RST;
			cfg_q.neighbour_count <= mgvu_pkg::NEIGHBOUR_RST;
		end else if (reg_wr) begin
			unique case (reg_sel)
				mgvu_pkg::REG_MOMENTUM:  cfg_q.momentum        <= pwdata;
				mgvu_pkg::REG_STEP_SIZE: cfg_q.step_size       <= pwdata;
				mgvu_pkg::REG_NEIGHBOUR: cfg_q.neighbour_count <= pwdata[7:0];
				default: ;   // unmapped word, write dropped
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_sel)
			mgvu_pkg::REG_MOMENTUM:  prdata = cfg_q.momentum;
			mgvu_pkg::REG_STEP_SIZE: prdata = cfg_q.step_size;
			mgvu_pkg::REG_NEIGHBOUR: prdata = {24'h000000, cfg_q.neighbour_count};
			default:                 prdata = '0;
		endcase
	end

	// sequencer, stores and shared multiplier
	mgvu_core #(
		.VECTOR_LENGTH (VECTOR_LENGTH)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

[sv/mgvu_chk.sv]
// port-level checker for the momentum gradient update block, bound to the top
// uses mgvu_pkg and assert_macros.svh
`include "assert_macros.svh"

module mgvu_chk (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  logic            item_stall,
	input  mgvu_pkg::in_t   item,
	input  logic            result_valid,
	input  logic            result_stall,
	input  mgvu_pkg::out_t  result
);

	logic item_acc, load_on_empty;

	assign item_acc      = item_valid && !item_stall;
	assign load_on_empty = item_acc && !result_valid &&
		(item.operation == mgvu_pkg::OP_LOAD);

	// one item at a time: busy right after a transaction is taken
	`AM_ASSERT_NEXT(busy_after_accept, item_acc, item_stall, "not busy after accept")

	// a stalled result stays put
	`AM_ASSERT_NEXT(result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

	// idle with nothing pending cannot produce a result next cycle
	`AM_ASSERT_NEXT(no_spurious_result, !item_stall && !result_valid, !result_valid, "result without item")

	// a load taken while no result is waiting shows its latent and zero velocity after write-back
	`AM_ASSERT(load_result, $past(load_on_empty, 2) |-> (result_valid && result.velocity_value == 0 && result.latent_value == $past(item.load_value, 2)), "load result wrong")

endmodule

bind momentum_gradient_vector_update mgvu_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

[sim/momentum_gradient_vector_update_tb.sv]
// self-checking testbench of momentum_gradient_vector_update: element loads, gradient
// accumulation and momentum updates checked against a q16.16 predictor of the block
// depends on mgvu_pkg and the momentum_gradient_vector_update rtl
module momentum_gradient_vector_update_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ELEMENTS = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 12;   // longest item is an update
	localparam logic [31:0] Q_ONE = 32'h0001_0000;
	localparam logic [31:0] Q_MINUS_ONE = 32'hffff_0000;

	// one expected result; known marks fields whose element entry has been written
	// (bit 2 latent, bit 1 gradient, bit 0 velocity)
	typedef struct {
		mgvu_pkg::out_t values;
		logic [2:0] known;
	} element_snapshot_t;

	typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_BURST} stall_mode_t;

	logic clk;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	mgvu_pkg::in_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	mgvu_pkg::out_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// predictor state: element stores, written flags and register copy
	logic signed [31:0] latent_mirror [ELEMENTS];
	logic signed [31:0] gradient_mirror [ELEMENTS];
	logic signed [31:0] velocity_mirror [ELEMENTS];
	logic latent_known [ELEMENTS];
	logic gradient_known [ELEMENTS];
	mgvu_pkg::cfg_t reg_mirror;

	// what the stimulus side has already sent, so it never reads an unwritten entry
	logic latent_planned [ELEMENTS];
	logic gradient_planned [ELEMENTS];

	element_snapshot_t pending_snapshots[$];

	int mismatch_count = 0;
	int results_checked = 0;
	int items_sent = 0;
	int load_count = 0;
	int accum_count = 0;
	int update_count = 0;
	int idle_op_count = 0;
	int setting_count = 0;
	int burst_left = 0;
	int cycle_count = 0;

	stall_mode_t stall_mode = STALL_NONE;
	int stall_left = 0;

	momentum_gradient_vector_update #(
		.VECTOR_LENGTH(ELEMENTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// 50 MHz clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycle_count,
				pending_snapshots.size());
			$display("momentum_gradient_vector_update_tb NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// q16.16 arithmetic of the predictor
	// ------------------------------------------------------------------

	// product of two q16.16 values, floor of the exact product over 2^16
	function automatic longint q_mul(input longint a, input longint b);
		return (a * b) >>> 16;
	endfunction

	function automatic logic signed [31:0] clamp_q(input longint x);
		if (x > 64'sd2147483647)
			return mgvu_pkg::SAT_MAX;
		if (x < -64'sd2147483648)
			return mgvu_pkg::SAT_MIN;
		return x[31:0];
	endfunction

	// applies one transaction to the predictor state and returns the element afterwards
	function automatic element_snapshot_t compute_element_result(input mgvu_pkg::in_t x);
		element_snapshot_t snap;
		int k;
		longint lat;
		longint g;
		longint v;
		k = int'(x.element_index);
		case (x.operation)
			mgvu_pkg::OP_LOAD: begin
				latent_mirror[k] = x.load_value;
				velocity_mirror[k] = '0;
				latent_known[k] = 1'b1;
			end
			mgvu_pkg::OP_ACCUM: begin
				g = q_mul(longint'(x.error_value), longint'(x.factor_value));
				if (!x.clear_first)
					g = g + longint'(gradient_mirror[k]);
				gradient_mirror[k] = clamp_q(g);
				gradient_known[k] = 1'b1;
			end
			mgvu_pkg::OP_UPDATE: begin
				lat = longint'(latent_mirror[k]);
				g = clamp_q(longint'(gradient_mirror[k])
					- q_mul(longint'(x.coef_value), longint'(x.prior_sum)));
				// neighbour term: floored product scaled by the integer count
				g = clamp_q(g + q_mul(longint'(x.coef_value), lat)
					* longint'(reg_mirror.neighbour_count));
				v = clamp_q(q_mul(longint'(reg_mirror.momentum),
					longint'(velocity_mirror[k]))
					+ q_mul(longint'(reg_mirror.step_size), g));
				gradient_mirror[k] = g[31:0];
				velocity_mirror[k] = v[31:0];
				latent_mirror[k] = clamp_q(lat - v);
			end
			default: begin
				// unused operation: element left as it is
			end
		endcase
		snap.values.latent_value = latent_mirror[k];
		snap.values.gradient_value = gradient_mirror[k];
		snap.values.velocity_value = velocity_mirror[k];
		// velocity is written by every load, so it is known exactly when latent is
		snap.known = {latent_known[k], gradient_known[k], latent_known[k]};
		return snap;
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch on %s: expected %h, got %h (result %0d)", what, want, got,
				results_checked);
	endtask

	task automatic check_result(input mgvu_pkg::out_t got);
		element_snapshot_t snap;
		if (pending_snapshots.size() == 0) begin
			report_mismatch("result with no transaction pending", 'x, got.latent_value);
		end else begin
			snap = pending_snapshots.pop_front();
			if (snap.known[2] && got.latent_value !== snap.values.latent_value)
				report_mismatch("latent_value", snap.values.latent_value, got.latent_value);
			if (snap.known[1] && got.gradient_value !== snap.values.gradient_value)
				report_mismatch("gradient_value", snap.values.gradient_value,
					got.gradient_value);
			if (snap.known[0] && got.velocity_value !== snap.values.velocity_value)
				report_mismatch("velocity_value", snap.values.velocity_value,
					got.velocity_value);
		end
		results_checked++;
	endtask

	// both channels are watched at the rising edge, before the block's registers move
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				pending_snapshots.insert(pending_snapshots.size(),
					compute_element_result(item));
				case (item.operation)
					mgvu_pkg::OP_LOAD: load_count++;
					mgvu_pkg::OP_ACCUM: accum_count++;
					mgvu_pkg::OP_UPDATE: update_count++;
					default: idle_op_count++;
				endcase
			end
			if (result_valid && !result_stall)
				check_result(result);
		end
	end

	// receiver back-pressure: modes of random length, from never to long stalls
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(20, 120);
		end
		stall_left--;
		case (stall_mode)
			STALL_NONE: result_stall <= 1'b0;
			STALL_COIN: result_stall <= 1'($urandom_range(0, 1));
			STALL_PERIODIC: result_stall <= (stall_left % 4) != 0;
			default: result_stall <= (stall_left % 16) < 9;
		endcase
	end

	// ------------------------------------------------------------------
	// register port
	// ------------------------------------------------------------------

	task automatic apb_write(input logic [1:0] reg_code, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_code, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (reg_code)
			mgvu_pkg::REG_MOMENTUM: reg_mirror.momentum = data;
			mgvu_pkg::REG_STEP_SIZE: reg_mirror.step_size = data;
			mgvu_pkg::REG_NEIGHBOUR: reg_mirror.neighbour_count = data[7:0];
			default: ;
		endcase
	endtask

	task automatic apb_read(input logic [1:0] reg_code, output logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {reg_code, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		data = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// read all three registers back against the local copy
	task automatic check_registers();
		logic [31:0] data;
		apb_read(mgvu_pkg::REG_MOMENTUM, data);
		if (data !== reg_mirror.momentum)
			report_mismatch("momentum register", reg_mirror.momentum, data);
		apb_read(mgvu_pkg::REG_STEP_SIZE, data);
		if (data !== reg_mirror.step_size)
			report_mismatch("step_size register", reg_mirror.step_size, data);
		apb_read(mgvu_pkg::REG_NEIGHBOUR, data);
		if (data[7:0] !== reg_mirror.neighbour_count)
			report_mismatch("neighbour_count register", 32'(reg_mirror.neighbour_count),
				data);
	endtask

	// ------------------------------------------------------------------
	// item channel
	// ------------------------------------------------------------------

	// drop valid and wait for every pending result, then let the pipeline empty
	task automatic settle(input int extra_cycles);
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_snapshots.size() != 0)
			@(posedge clk);
		repeat (extra_cycles)
			@(posedge clk);
	endtask

	task automatic configure(input logic [31:0] momentum, input logic [31:0] step_size,
		input logic [7:0] neighbours);
		settle(SETTLE_CYCLES);
		apb_write(mgvu_pkg::REG_MOMENTUM, momentum);
		apb_write(mgvu_pkg::REG_STEP_SIZE, step_size);
		apb_write(mgvu_pkg::REG_NEIGHBOUR, {24'd0, neighbours});
		check_registers();
		setting_count++;
	endtask

	task automatic idle_for(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
	endtask

	// one transaction; the sender works in bursts with random gaps between them
	task automatic send_transaction(input mgvu_pkg::in_t x);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 24);
			if ($urandom_range(0, 4) != 0)
				idle_for($urandom_range(1, 6));
		end
		burst_left--;
		@(negedge clk);
		item_valid <= 1'b1;
		item <= x;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		items_sent++;
		if (x.operation == mgvu_pkg::OP_LOAD)
			latent_planned[x.element_index] = 1'b1;
		if (x.operation == mgvu_pkg::OP_ACCUM && x.clear_first)
			gradient_planned[x.element_index] = 1'b1;
	endtask

	function automatic mgvu_pkg::in_t make_item(input logic [1:0] op, input logic [3:0] idx,
		input logic clr, input logic [31:0] err, input logic [31:0] fac,
		input logic [31:0] prior, input logic [31:0] coef, input logic [31:0] load);
		mgvu_pkg::in_t x;
		x.operation = op;
		x.element_index = idx;
		x.clear_first = clr;
		x.error_value = err;
		x.factor_value = fac;
		x.prior_sum = prior;
		x.coef_value = coef;
		x.load_value = load;
		return x;
	endfunction

	// values within +-4.0, where the dynamics stay away from saturation
	function automatic logic [31:0] q_small();
		return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
	endfunction

	function automatic logic [31:0] q_value();
		case ($urandom_range(0, 7))
			0: return mgvu_pkg::SAT_MAX;
			1: return mgvu_pkg::SAT_MIN;
			2, 3, 4: return $urandom;
			default: return q_small();
		endcase
	endfunction

	function automatic logic [31:0] q_mostly_small();
		return ($urandom_range(0, 7) == 0) ? q_value() : q_small();
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	task automatic test_register_defaults();
		check_registers();
	endtask

	// corner items under extreme register settings
	task automatic test_corner_items();
		configure(mgvu_pkg::SAT_MAX, mgvu_pkg::SAT_MIN, 8'd255);
		// largest latent, gradient saturating high then low, update and idle operation
		send_transaction(make_item(mgvu_pkg::OP_LOAD, 4'd0, 1'b0, 0, 0, 0, 0,
			mgvu_pkg::SAT_MAX));
		send_transaction(make_item(mgvu_pkg::OP_ACCUM, 4'd0, 1'b1, mgvu_pkg::SAT_MAX,
			mgvu_pkg::SAT_MAX, 0, 0, 0));
		send_transaction(make_item(mgvu_pkg::OP_ACCUM, 4'd0, 1'b0, mgvu_pkg::SAT_MIN,
			mgvu_pkg::SAT_MAX, 0, 0, 0));
		send_transaction(make_item(mgvu_pkg::OP_UPDATE, 4'd0, 1'b1, 0, 0, mgvu_pkg::SAT_MIN,
			mgvu_pkg::SAT_MAX, 0));
		send_transaction(make_item(mgvu_pkg::OP_NONE, 4'd0, 1'b1, mgvu_pkg::SAT_MAX,
			mgvu_pkg::SAT_MAX, mgvu_pkg::SAT_MAX, mgvu_pkg::SAT_MAX, mgvu_pkg::SAT_MAX));
		// most negative latent, error and factor; updates with the most negative coefficient
		send_transaction(make_item(mgvu_pkg::OP_LOAD, 4'd1, 1'b1, 0, 0, 0, 0,
			mgvu_pkg::SAT_MIN));
		send_transaction(make_item(mgvu_pkg::OP_ACCUM, 4'd1, 1'b1, mgvu_pkg::SAT_MIN,
			mgvu_pkg::SAT_MIN, 0, 0, 0));
		send_transaction(make_item(mgvu_pkg::OP_UPDATE, 4'd1, 1'b0, 0, 0, mgvu_pkg::SAT_MAX,
			mgvu_pkg::SAT_MIN, 0));
		send_transaction(make_item(mgvu_pkg::OP_UPDATE, 4'd1, 1'b0, 0, 0, mgvu_pkg::SAT_MAX,
			mgvu_pkg::SAT_MIN, 0));
		// floor rounding of tiny products: -1 lsb stays -1, +1 lsb vanishes
		send_transaction(make_item(mgvu_pkg::OP_LOAD, 4'd2, 1'b0, 0, 0, 0, 0, 0));
		send_transaction(make_item(mgvu_pkg::OP_ACCUM, 4'd2, 1'b1, Q_ONE, Q_ONE, 0, 0, 0));
		send_transaction(make_item(mgvu_pkg::OP_ACCUM, 4'd2, 1'b0, 32'hffff_ffff, 32'd1,
			0, 0, 0));
		send_transaction(make_item(mgvu_pkg::OP_ACCUM, 4'd2, 1'b0, 32'd1, 32'd1, 0, 0, 0));
		send_transaction(make_item(mgvu_pkg::OP_UPDATE, 4'd2, 1'b0, 0, 0, 0, 0, 0));
		send_transaction(make_item(mgvu_pkg::OP_ACCUM, 4'd2, 1'b1, 0, 0, 0, 0, 0));
		send_transaction(make_item(mgvu_pkg::OP_UPDATE, 4'd2, 1'b0, 0, 0, Q_ONE,
			Q_MINUS_ONE, 0));
		// top element; a second load clears velocity but keeps the gradient
		send_transaction(make_item(mgvu_pkg::OP_LOAD, 4'd15, 1'b0, 0, 0, 0, 0, Q_ONE));
		send_transaction(make_item(mgvu_pkg::OP_ACCUM, 4'd15, 1'b1, Q_ONE, Q_MINUS_ONE,
			0, 0, 0));
		send_transaction(make_item(mgvu_pkg::OP_UPDATE, 4'd15, 1'b0, 0, 0, Q_ONE, Q_ONE, 0));
		send_transaction(make_item(mgvu_pkg::OP_LOAD, 4'd15, 1'b1, 0, 0, 0, 0,
			mgvu_pkg::SAT_MIN));
		send_transaction(make_item(mgvu_pkg::OP_NONE, 4'd15, 1'b0, 0, 0, 0, 0, 0));
	endtask

	// well-formed pass over one element: optional load, gradient build-up, update
	task automatic train_element(input logic [3:0] k);
		if (!latent_planned[k] || $urandom_range(0, 5) == 0)
			send_transaction(make_item(mgvu_pkg::OP_LOAD, k, 1'($urandom_range(0, 1)),
				q_value(), q_value(), q_value(), q_value(), q_mostly_small()));
		send_transaction(make_item(mgvu_pkg::OP_ACCUM, k, 1'b1, q_mostly_small(),
			q_mostly_small(), q_value(), q_value(), q_value()));
		repeat ($urandom_range(0, 4))
			send_transaction(make_item(mgvu_pkg::OP_ACCUM, k, 1'b0, q_mostly_small(),
				q_mostly_small(), q_value(), q_value(), q_value()));
		repeat ($urandom_range(1, 2))
			send_transaction(make_item(mgvu_pkg::OP_UPDATE, k, 1'($urandom_range(0, 1)),
				q_value(), q_value(), q_mostly_small(), q_mostly_small(), q_value()));
	endtask

	// any operation with any content, as long as the element's entries are written
	task automatic send_noise_item();
		logic [3:0] k;
		logic [1:0] op;
		logic clr;
		k = 4'($urandom_range(0, ELEMENTS - 1));
		op = 2'($urandom_range(0, 3));
		clr = 1'($urandom_range(0, 1));
		if (!latent_planned[k]) begin
			op = mgvu_pkg::OP_LOAD;
		end else if (!gradient_planned[k]) begin
			op = mgvu_pkg::OP_ACCUM;
			clr = 1'b1;
		end
		send_transaction(make_item(op, k, clr, q_value(), q_value(), q_value(), q_value(),
			q_value()));
	endtask

	task automatic test_training_phase(input logic [31:0] momentum,
		input logic [31:0] step_size, input logic [7:0] neighbours, input int count);
		int target;
		int pause_at;
		bit paused;
		configure(momentum, step_size, neighbours);
		target = items_sent + count;
		pause_at = items_sent + $urandom_range(count / 4, 3 * count / 4);
		paused = 1'b0;
		while (items_sent < target) begin
			if ($urandom_range(0, 9) < 8)
				train_element(4'($urandom_range(0, ELEMENTS - 1)));
			else
				send_noise_item();
			// hold the sender until the block has answered everything
			if (!paused && items_sent >= pause_at) begin
				settle(0);
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		for (int i = 0; i < ELEMENTS; i++) begin
			latent_known[i] = 1'b0;
			gradient_known[i] = 1'b0;
			latent_planned[i] = 1'b0;
			gradient_planned[i] = 1'b0;
			latent_mirror[i] = '0;
			gradient_mirror[i] = '0;
			velocity_mirror[i] = '0;
		end
		reg_mirror.momentum = mgvu_pkg::MOMENTUM_RST;
		reg_mirror.step_size = mgvu_pkg::STEP_SIZE_RST;
		reg_mirror.neighbour_count = mgvu_pkg::NEIGHBOUR_RST;

		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_register_defaults();
		test_corner_items();
		test_training_phase(mgvu_pkg::MOMENTUM_RST, mgvu_pkg::STEP_SIZE_RST,
			mgvu_pkg::NEIGHBOUR_RST, 330);
		test_training_phase(32'd0, 32'd0, 8'd0, 330);
		test_training_phase(32'd58982, 32'd3277, 8'd4, 330);
		test_training_phase($urandom, $urandom, 8'($urandom_range(0, 255)), 330);
		test_training_phase(mgvu_pkg::SAT_MIN, mgvu_pkg::SAT_MAX, 8'd255, 330);

		settle(SETTLE_CYCLES);
		$display("covered %0d loads, %0d accumulates, %0d updates and %0d unused operations",
			load_count, accum_count, update_count, idle_op_count);
		$display("over %0d register settings; %0d results checked, %0d mismatches",
			setting_count, results_checked, mismatch_count);
		if (mismatch_count == 0) begin
			$display("momentum_gradient_vector_update_tb OK");
		end else begin
			$display("momentum_gradient_vector_update_tb NOT OK");
		end
		$finish;
	end

endmodule
